FILE: hw/rtl/gfba_pkg.sv
package gfba_pkg;

    localparam int GROUPS_DEF         = 8;
    localparam int DATA_PER_GROUP_DEF = 63;
    localparam int STACK_DEPTH_DEF    = 32;

    localparam int GRP_W_MAX   = 6;
    localparam int REC_AW_MAX  = 24;

    localparam logic [15:0] ZONE_START_RST = 16'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NONE   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    typedef struct packed {
        logic        action;
        logic [2:0]  hint_group;
        logic [15:0] block;
        logic        reserved_block;
    } req_t;

    typedef struct packed {
        logic [15:0] granted_block;
        logic [1:0]  status;
    } rsp_t;

    typedef struct packed {
        logic                  ok;
        logic [GRP_W_MAX-1:0]  grp;
        logic [REC_AW_MAX-1:0] base;
    } loc_t;

    function automatic logic [GRP_W_MAX-1:0] wrap_hint(input logic [2:0] h, input int g);
        int v;
        v = int'(h);
        for (int i = 0; i < 8; i++)
        begin
            if (v >= g)
            begin
                v = v - g;
            end
        end
        return GRP_W_MAX'(v);
    endfunction

endpackage

FILE: hw/rtl/gfba_ram.sv
module gfba_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int W     = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/gfba_locate.sv
module gfba_locate #(
    parameter int GROUPS         = 8,
    parameter int DATA_PER_GROUP = 63,
    parameter int STACK_DEPTH    = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [15:0]        blk,
    input  logic [15:0]        zone_start,
    output logic               done,
    output gfba_pkg::loc_t     res
);
    import gfba_pkg::*;

    localparam int REC_WORDS = STACK_DEPTH + 2;
    localparam int RAW       = $clog2(GROUPS * DATA_PER_GROUP * REC_WORDS);
    localparam int CW        = $clog2(GROUPS + 1);
    localparam int GSPAN     = DATA_PER_GROUP + 1;
    localparam int GSTRIDE   = DATA_PER_GROUP * REC_WORDS;

    logic          run_reg;
    logic          bad_reg;
    logic [15:0]   rem_reg;
    logic [CW-1:0] cnt_reg;
    logic [RAW-1:0] base_reg;
    logic          done_reg;
    loc_t          res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                bad_reg  <= blk < zone_start;
                rem_reg  <= blk - zone_start;
                cnt_reg  <= '0;
                base_reg <= '0;
            end
            else if (run_reg)
            begin
                if (bad_reg || cnt_reg == CW'(GROUPS))
                begin
                    run_reg    <= 1'b0;
                    done_reg   <= 1'b1;
                    res_reg.ok <= 1'b0;
                end
                else if (rem_reg >= 16'(GSPAN))
                begin
                    rem_reg  <= rem_reg - 16'(GSPAN);
                    cnt_reg  <= cnt_reg + 1'b1;
                    base_reg <= base_reg + RAW'(GSTRIDE);
                end
                else
                begin
                    run_reg      <= 1'b0;
                    done_reg     <= 1'b1;
                    res_reg.ok   <= rem_reg != 16'd0;
                    res_reg.grp  <= GRP_W_MAX'(cnt_reg);
                    res_reg.base <= REC_AW_MAX'(base_reg
                        + RAW'((rem_reg - 16'd1) * 16'(REC_WORDS)));
                end
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

FILE: hw/rtl/grouped_free_block_allocator.sv
// Grouped free block allocator.
// Request channel: a request (req) is taken at a rising edge with start high and busy low.
// busy stays high while the request is worked on and drops in the cycle that shows the result.
// Result channel: rsp is valid for exactly one cycle, marked by done; the receiver cannot
// stall it, so no result is ever held back.
// Config channel: cfg_valid/cfg_ready write zone_start; cfg_ready is always high. Write it
// only while busy is low.
// Operation: a free locates the block's group and pushes the block onto that group's stack; a
// free that finds its stack full first spills the stack into the block's record.
// An allocate pops from the hint group when it has stacked blocks, else passes over groups in
// turn, locating each chain block and refilling the stack from its record; the scan covers up
// to GROUPS groups. One request at a time.
// Reset: all per-group state clears at once, zone_start returns to 2, no clearing pass.
module grouped_free_block_allocator #(
    parameter int GROUPS         = gfba_pkg::GROUPS_DEF,
    parameter int DATA_PER_GROUP = gfba_pkg::DATA_PER_GROUP_DEF,
    parameter int STACK_DEPTH    = gfba_pkg::STACK_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  gfba_pkg::req_t req,
    output logic           done,
    output gfba_pkg::rsp_t rsp,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [15:0]    cfg_data
);
    import gfba_pkg::*;

    localparam int REC_WORDS = STACK_DEPTH + 2;
    localparam int REC_DEPTH = GROUPS * DATA_PER_GROUP * REC_WORDS;
    localparam int RAW       = $clog2(REC_DEPTH);
    localparam int STK_DEPTH = GROUPS * STACK_DEPTH;
    localparam int SAW       = (STK_DEPTH > 1) ? $clog2(STK_DEPTH) : 1;
    localparam int GW        = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int CW        = $clog2(GROUPS + 1);
    localparam int HW        = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_POP, S_RF_LOC, S_RF_CNT, S_RF_COPY, S_RF_TAIL,
        S_FR_LOC, S_SP_COPY, S_SP_HEAD, S_SP_FIN
    } state_t;

    state_t         state_reg, state_next;
    req_t           req_reg, req_next;
    logic [GW-1:0]  grp_reg, grp_next;
    logic [CW-1:0]  pass_reg, pass_next;
    logic [HW-1:0]  height_reg [GROUPS];
    logic [HW-1:0]  height_next [GROUPS];
    logic [15:0]    chain_reg [GROUPS];
    logic [15:0]    chain_next [GROUPS];
    logic [15:0]    count_reg [GROUPS];
    logic [15:0]    count_next [GROUPS];
    logic [15:0]    zone_reg;
    logic [HW-1:0]  idx_reg, idx_next;
    logic [HW-1:0]  widx_reg, widx_next;
    logic [HW-1:0]  m_reg, m_next;
    logic           rvalid_reg, rvalid_next;
    logic [RAW-1:0] base_reg, base_next;
    logic           done_reg, done_next;
    rsp_t           rsp_reg, rsp_next;

    logic           stk_we;
    logic [SAW-1:0] stk_waddr, stk_raddr;
    logic [15:0]    stk_wdata, stk_rdata;
    logic           rec_we;
    logic [RAW-1:0] rec_waddr, rec_raddr;
    logic [15:0]    rec_wdata, rec_rdata;

    logic           loc_start;
    logic [15:0]    loc_blk;
    logic           loc_done;
    loc_t           loc_res;

    logic [SAW-1:0] grp_row;
    logic [GW-1:0]  lgrp;
    logic [SAW-1:0] lgrp_row;

    assign grp_row  = SAW'(grp_reg) * SAW'(STACK_DEPTH);
    assign lgrp     = GW'(loc_res.grp);
    assign lgrp_row = SAW'(lgrp) * SAW'(STACK_DEPTH);

    gfba_ram #(.DEPTH(STK_DEPTH), .AW(SAW), .W(16)) u_stk (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    gfba_ram #(.DEPTH(REC_DEPTH), .AW(RAW), .W(16)) u_rec (
        .clk   (clk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata (rec_wdata),
        .raddr (rec_raddr),
        .rdata (rec_rdata)
    );

    gfba_locate #(
        .GROUPS         (GROUPS),
        .DATA_PER_GROUP (DATA_PER_GROUP),
        .STACK_DEPTH    (STACK_DEPTH)
    ) u_loc (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (loc_start),
        .blk        (loc_blk),
        .zone_start (zone_reg),
        .done       (loc_done),
        .res        (loc_res)
    );

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        grp_next    = grp_reg;
        pass_next   = pass_reg;
        height_next = height_reg;
        chain_next  = chain_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        widx_next   = widx_reg;
        m_next      = m_reg;
        rvalid_next = 1'b0;
        base_next   = base_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        stk_we      = 1'b0;
        stk_waddr   = '0;
        stk_wdata   = '0;
        stk_raddr   = '0;
        rec_we      = 1'b0;
        rec_waddr   = '0;
        rec_wdata   = '0;
        rec_raddr   = '0;
        loc_start   = 1'b0;
        loc_blk     = req_reg.block;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    if (req.action == ACT_ALLOC)
                    begin
                        grp_next   = GW'(wrap_hint(req.hint_group, GROUPS));
                        pass_next  = '0;
                        state_next = S_SCAN;
                    end
                    else if (req.reserved_block)
                    begin
                        done_next  = 1'b1;
                        rsp_next   = '{granted_block: 16'd0, status: ST_REJECT};
                    end
                    else
                    begin
                        loc_start  = 1'b1;
                        loc_blk    = req.block;
                        state_next = S_FR_LOC;
                    end
                end
            end

            S_SCAN:
            begin
                if (count_reg[grp_reg] != 16'd0 && height_reg[grp_reg] != '0)
                begin
                    stk_raddr            = grp_row + SAW'(height_reg[grp_reg] - 1'b1);
                    height_next[grp_reg] = height_reg[grp_reg] - 1'b1;
                    count_next[grp_reg]  = count_reg[grp_reg] - 16'd1;
                    state_next           = S_POP;
                end
                else if (count_reg[grp_reg] != 16'd0 && chain_reg[grp_reg] != 16'd0)
                begin
                    loc_start  = 1'b1;
                    loc_blk    = chain_reg[grp_reg];
                    state_next = S_RF_LOC;
                end
                else if (pass_reg == CW'(GROUPS - 1))
                begin
                    done_next  = 1'b1;
                    rsp_next   = '{granted_block: 16'd0, status: ST_NONE};
                    state_next = S_IDLE;
                end
                else
                begin
                    pass_next = pass_reg + 1'b1;
                    grp_next  = (grp_reg == GW'(GROUPS - 1)) ? '0 : grp_reg + 1'b1;
                end
            end

            S_POP:
            begin
                done_next  = 1'b1;
                rsp_next   = '{granted_block: stk_rdata, status: ST_OK};
                state_next = S_IDLE;
            end

            S_RF_LOC:
            begin
                if (loc_done)
                begin
                    if (loc_res.ok)
                    begin
                        base_next  = RAW'(loc_res.base);
                        rec_raddr  = RAW'(loc_res.base);
                        state_next = S_RF_CNT;
                    end
                    else
                    begin
                        height_next[grp_reg] = '0;
                        count_next[grp_reg]  = 16'd0;
                        count_next[grp_reg]  = count_reg[grp_reg];
                        chain_next[grp_reg]  = chain_reg[grp_reg];
                        // skip the group: treat as empty for this scan
                        state_next = S_SCAN;
                        if (pass_reg == CW'(GROUPS - 1))
                        begin
                            done_next  = 1'b1;
                            rsp_next   = '{granted_block: 16'd0, status: ST_NONE};
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            pass_next = pass_reg + 1'b1;
                            grp_next  = (grp_reg == GW'(GROUPS - 1)) ? '0 : grp_reg + 1'b1;
                        end
                    end
                end
            end

            S_RF_CNT:
            begin
                if (rec_rdata == 16'd0 || rec_rdata > 16'(STACK_DEPTH))
                begin
                    state_next = S_SCAN;
                    if (pass_reg == CW'(GROUPS - 1))
                    begin
                        done_next  = 1'b1;
                        rsp_next   = '{granted_block: 16'd0, status: ST_NONE};
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pass_next = pass_reg + 1'b1;
                        grp_next  = (grp_reg == GW'(GROUPS - 1)) ? '0 : grp_reg + 1'b1;
                    end
                end
                else
                begin
                    m_next     = HW'(rec_rdata);
                    idx_next   = '0;
                    state_next = S_RF_COPY;
                end
            end

            S_RF_COPY:
            begin
                if (rvalid_reg)
                begin
                    stk_we    = 1'b1;
                    stk_waddr = grp_row + SAW'(widx_reg);
                    stk_wdata = rec_rdata;
                end
                if (idx_reg != m_reg)
                begin
                    rec_raddr   = base_reg + RAW'(idx_reg) + RAW'(1);
                    rvalid_next = 1'b1;
                    widx_next   = idx_reg;
                    idx_next    = idx_reg + 1'b1;
                end
                else
                begin
                    rec_raddr  = base_reg + RAW'(m_reg) + RAW'(1);
                    state_next = S_RF_TAIL;
                end
            end

            S_RF_TAIL:
            begin
                chain_next[grp_reg] = rec_rdata;
                if (m_reg < HW'(STACK_DEPTH))
                begin
                    stk_we               = 1'b1;
                    stk_waddr            = grp_row + SAW'(m_reg);
                    stk_wdata            = chain_reg[grp_reg];
                    height_next[grp_reg] = m_reg + 1'b1;
                end
                else
                begin
                    height_next[grp_reg] = m_reg;
                end
                state_next = S_SCAN;
            end

            S_FR_LOC:
            begin
                if (loc_done)
                begin
                    if (!loc_res.ok)
                    begin
                        done_next  = 1'b1;
                        rsp_next   = '{granted_block: 16'd0, status: ST_REJECT};
                        state_next = S_IDLE;
                    end
                    else if (height_reg[lgrp] >= HW'(STACK_DEPTH))
                    begin
                        grp_next   = lgrp;
                        base_next  = RAW'(loc_res.base);
                        idx_next   = '0;
                        state_next = S_SP_COPY;
                    end
                    else
                    begin
                        stk_we            = 1'b1;
                        stk_waddr         = lgrp_row + SAW'(height_reg[lgrp]);
                        stk_wdata         = req_reg.block;
                        height_next[lgrp] = height_reg[lgrp] + 1'b1;
                        if (count_reg[lgrp] != 16'hFFFF)
                        begin
                            count_next[lgrp] = count_reg[lgrp] + 16'd1;
                        end
                        done_next  = 1'b1;
                        rsp_next   = '{granted_block: 16'd0, status: ST_OK};
                        state_next = S_IDLE;
                    end
                end
            end

            S_SP_COPY:
            begin
                if (rvalid_reg)
                begin
                    rec_we    = 1'b1;
                    rec_waddr = base_reg + RAW'(widx_reg) + RAW'(1);
                    rec_wdata = stk_rdata;
                end
                if (idx_reg != HW'(STACK_DEPTH))
                begin
                    stk_raddr   = grp_row + SAW'(idx_reg);
                    rvalid_next = 1'b1;
                    widx_next   = idx_reg;
                    idx_next    = idx_reg + 1'b1;
                end
                else
                begin
                    state_next = S_SP_HEAD;
                end
            end

            S_SP_HEAD:
            begin
                rec_we     = 1'b1;
                rec_waddr  = base_reg;
                rec_wdata  = 16'(STACK_DEPTH);
                state_next = S_SP_FIN;
            end

            S_SP_FIN:
            begin
                rec_we               = 1'b1;
                rec_waddr            = base_reg + RAW'(STACK_DEPTH + 1);
                rec_wdata            = chain_reg[grp_reg];
                chain_next[grp_reg]  = req_reg.block;
                height_next[grp_reg] = HW'(1);
                stk_we               = 1'b1;
                stk_waddr            = grp_row;
                stk_wdata            = req_reg.block;
                if (count_reg[grp_reg] != 16'hFFFF)
                begin
                    count_next[grp_reg] = count_reg[grp_reg] + 16'd1;
                end
                done_next  = 1'b1;
                rsp_next   = '{granted_block: 16'd0, status: ST_OK};
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            rvalid_reg <= 1'b0;
            zone_reg   <= ZONE_START_RST;
            for (int i = 0; i < GROUPS; i++)
            begin
                height_reg[i] <= '0;
                chain_reg[i]  <= '0;
                count_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            rvalid_reg <= rvalid_next;
            height_reg <= height_next;
            chain_reg  <= chain_next;
            count_reg  <= count_next;
            if (cfg_valid)
            begin
                zone_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        grp_reg  <= grp_next;
        pass_reg <= pass_next;
        idx_reg  <= idx_next;
        widx_reg <= widx_next;
        m_reg    <= m_next;
        base_reg <= base_next;
        rsp_reg  <= rsp_next;
    end

    assign busy      = state_reg != S_IDLE;
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

endmodule

FILE: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gfba_pkg::*;

    localparam int NGRP     = GROUPS_DEF;
    localparam int NDATA    = DATA_PER_GROUP_DEF;
    localparam int DEPTH    = STACK_DEPTH_DEF;
    localparam int REC_LEN  = DEPTH + 2;
    localparam int NSLOTS   = NGRP * NDATA;
    localparam int N_RANDOM = 1600;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        req;
    logic        done;
    rsp_t        rsp;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    grouped_free_block_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // allocator shadow state
    logic [15:0] zone;
    logic [15:0] stk_mem [NGRP*DEPTH];
    int          stk_ht [NGRP];
    logic [15:0] chain [NGRP];
    logic [15:0] free_cnt [NGRP];
    logic [15:0] rec_mem [NSLOTS*REC_LEN];

    rsp_t        pending_rsp [$];
    int          errors;
    int          n_sent;
    int          idle_pct;

    typedef struct packed {
        req_t r;
        logic chk;
        rsp_t e;
    } dir_row_t;

    localparam dir_row_t DIR_TAB [19] = '{
        '{'{ACT_ALLOC, 3'd0, 16'd0,     1'b0}, 1'b1, '{16'd0,   ST_NONE}},
        '{'{ACT_FREE,  3'd0, 16'd0,     1'b0}, 1'b1, '{16'd0,   ST_REJECT}},
        '{'{ACT_FREE,  3'd0, 16'd2,     1'b0}, 1'b1, '{16'd0,   ST_REJECT}},
        '{'{ACT_FREE,  3'd0, 16'd3,     1'b1}, 1'b1, '{16'd0,   ST_REJECT}},
        '{'{ACT_FREE,  3'd7, 16'hFFFF,  1'b0}, 1'b1, '{16'd0,   ST_REJECT}},
        '{'{ACT_FREE,  3'd0, 16'd514,   1'b0}, 1'b1, '{16'd0,   ST_REJECT}},
        '{'{ACT_FREE,  3'd0, 16'd3,     1'b0}, 1'b1, '{16'd0,   ST_OK}},
        '{'{ACT_FREE,  3'd0, 16'd513,   1'b0}, 1'b1, '{16'd0,   ST_OK}},
        '{'{ACT_ALLOC, 3'd7, 16'hFFFF,  1'b1}, 1'b1, '{16'd513, ST_OK}},
        '{'{ACT_ALLOC, 3'd7, 16'd0,     1'b0}, 1'b1, '{16'd3,   ST_OK}},
        '{'{ACT_ALLOC, 3'd5, 16'd0,     1'b0}, 1'b1, '{16'd0,   ST_NONE}},
        '{'{ACT_FREE,  3'd0, 16'd66,    1'b0}, 1'b1, '{16'd0,   ST_REJECT}},
        '{'{ACT_FREE,  3'd7, 16'd67,    1'b0}, 1'b1, '{16'd0,   ST_OK}},
        '{'{ACT_ALLOC, 3'd1, 16'd0,     1'b0}, 1'b1, '{16'd67,  ST_OK}},
        '{'{ACT_FREE,  3'd2, 16'd3,     1'b0}, 1'b0, '{16'd0,   ST_OK}},
        '{'{ACT_FREE,  3'd4, 16'd3,     1'b0}, 1'b0, '{16'd0,   ST_OK}},
        '{'{ACT_ALLOC, 3'd6, 16'd0,     1'b0}, 1'b0, '{16'd0,   ST_OK}},
        '{'{ACT_ALLOC, 3'd3, 16'd0,     1'b0}, 1'b0, '{16'd0,   ST_OK}},
        '{'{ACT_ALLOC, 3'd0, 16'd0,     1'b0}, 1'b0, '{16'd0,   ST_OK}}
    };

    function automatic bit find_slot(input logic [15:0] b, output int g, output int slot);
        int off;
        int r;
        if (b < zone)
            return 0;
        off = int'(b) - int'(zone);
        g = off / (NDATA + 1);
        r = off % (NDATA + 1);
        if (g >= NGRP || r == 0)
            return 0;
        slot = g * NDATA + r - 1;
        return 1;
    endfunction

    function automatic bit reload_stack(input int g);
        int cg;
        int slot;
        int base;
        int m;
        if (chain[g] == 16'd0)
            return 0;
        if (!find_slot(chain[g], cg, slot))
            return 0;
        base = slot * REC_LEN;
        m = int'(rec_mem[base]);
        if (m == 0 || m > DEPTH)
            return 0;
        for (int j = 0; j < m; j++)
            stk_mem[g*DEPTH + j] = rec_mem[base + 1 + j];
        if (m < DEPTH)
        begin
            stk_mem[g*DEPTH + m] = chain[g];
            stk_ht[g] = m + 1;
        end
        else
        begin
            stk_ht[g] = m;
        end
        chain[g] = rec_mem[base + m + 1];
        return 1;
    endfunction

    function automatic rsp_t alloc_or_free(input req_t r);
        rsp_t o;
        int   g;
        int   slot;
        int   base;
        o = '{16'd0, ST_OK};
        if (r.action == ACT_ALLOC)
        begin
            for (int p = 0; p < NGRP; p++)
            begin
                g = (int'(r.hint_group) % NGRP + p) % NGRP;
                if (free_cnt[g] == 16'd0)
                    continue;
                if (stk_ht[g] == 0 && !reload_stack(g))
                    continue;
                stk_ht[g]--;
                o.granted_block = stk_mem[g*DEPTH + stk_ht[g]];
                free_cnt[g]--;
                return o;
            end
            o.status = ST_NONE;
            return o;
        end
        if (r.reserved_block || !find_slot(r.block, g, slot))
        begin
            o.status = ST_REJECT;
            return o;
        end
        if (stk_ht[g] >= DEPTH)
        begin
            // full stack spills into the freed block, which starts a new chain link
            base = slot * REC_LEN;
            rec_mem[base] = 16'(DEPTH);
            for (int k = 0; k < DEPTH; k++)
                rec_mem[base + 1 + k] = stk_mem[g*DEPTH + k];
            rec_mem[base + DEPTH + 1] = chain[g];
            chain[g] = r.block;
            stk_ht[g] = 1;
            stk_mem[g*DEPTH] = r.block;
        end
        else
        begin
            stk_mem[g*DEPTH + stk_ht[g]] = r.block;
            stk_ht[g]++;
        end
        if (free_cnt[g] != 16'hFFFF)
            free_cnt[g]++;
        return o;
    endfunction

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // result check
    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: block %0d status %0d",
                             rsp.granted_block, rsp.status);
            end
            else
            begin
                exp_rsp = pending_rsp.pop_front();
                if (rsp.granted_block !== exp_rsp.granted_block ||
                    rsp.status !== exp_rsp.status)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected block %0d status %0d, got %0d %0d",
                                 exp_rsp.granted_block, exp_rsp.status,
                                 rsp.granted_block, rsp.status);
                end
            end
        end
    end

    task automatic send(input req_t r, input bit chk, input rsp_t e);
        rsp_t p;
        @(negedge clk);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(negedge clk);
        end
        req   <= r;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        p = alloc_or_free(r);
        pending_rsp.push_back(chk ? e : p);
        n_sent++;
        #1;
    endtask

    task automatic send_req(input req_t r);
        send(r, 1'b0, '{16'd0, ST_OK});
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    function automatic int total_free();
        int s;
        s = 0;
        for (int g = 0; g < NGRP; g++)
            s += int'(free_cnt[g]);
        return s;
    endfunction

    function automatic bit chains_empty();
        for (int g = 0; g < NGRP; g++)
            if (chain[g] != 16'd0)
                return 0;
        return 1;
    endfunction

    // empty every group so no chain head can point at a record that was never written
    task automatic set_zone(input logic [15:0] z);
        req_t r;
        int   guard;
        guard = 0;
        while (total_free() > 0 && guard < 4000)
        begin
            r = '{ACT_ALLOC, 3'($urandom_range(0, 7)), 16'($urandom), 1'($urandom)};
            send_req(r);
            guard++;
        end
        wait_drained();
        if (!chains_empty())
            return;
        cfg_data  <= z;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        zone = z;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic req_t rand_req(input int focus);
        req_t r;
        int   sel;
        int   g;
        int   b;
        sel = $urandom_range(0, 99);
        r = '{ACT_ALLOC, 3'($urandom_range(0, 7)), 16'($urandom), 1'b0};
        if (sel < 55)
        begin
            g = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NGRP - 1) : focus;
            b = int'(zone) + g * (NDATA + 1) + $urandom_range(1, NDATA);
            r.action = ACT_FREE;
            r.block = (b > 65535) ? 16'($urandom) : 16'(b);
            r.reserved_block = ($urandom_range(0, 19) == 0);
        end
        else if (sel >= 88)
        begin
            r.action = 1'($urandom);
            r.reserved_block = 1'($urandom);
        end
        return r;
    endfunction

    task automatic random_phase(input int n_items);
        int focus;
        focus = $urandom_range(0, NGRP - 1);
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 40 == 0)
                focus = $urandom_range(0, NGRP - 1);
            if (n_sent < N_RANDOM / 3)
                idle_pct = 22;
            else if (n_sent < 2 * N_RANDOM / 3)
                idle_pct = 67;
            else
                idle_pct = 0;
            if (i == n_items / 2)
                wait_drained();
            send_req(rand_req(focus));
        end
    endtask

    initial
    begin
        logic [15:0] zones [5];
        zones = '{16'd0, 16'd1000, 16'hFFFF, 16'hFFC0, 16'd2};
        errors    = 0;
        n_sent    = 0;
        idle_pct  = 22;
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_data  = 16'd0;
        zone      = ZONE_START_RST;
        for (int i = 0; i < NGRP * DEPTH; i++)
            stk_mem[i] = 16'd0;
        for (int i = 0; i < NGRP; i++)
        begin
            stk_ht[i]   = 0;
            chain[i]    = 16'd0;
            free_cnt[i] = 16'd0;
        end
        for (int i = 0; i < NSLOTS * REC_LEN; i++)
            rec_mem[i] = 16'd0;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIR_TAB[i])
            send(DIR_TAB[i].r, DIR_TAB[i].chk, DIR_TAB[i].e);

        random_phase(500);
        foreach (zones[z])
        begin
            set_zone(zones[z]);
            random_phase((zones[z] == 16'hFFFF) ? 100 : 250);
        end

        wait_drained();
        repeat (40)
            @(posedge clk);
        if (errors == 0 && pending_rsp.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/gfba_pkg.sv
hw/rtl/gfba_ram.sv
hw/rtl/gfba_locate.sv
hw/rtl/grouped_free_block_allocator.sv
tb/testbench.sv
